[rtl/two_pass_rms_current_meter_assert.svh]
// Assertion macros for the two-pass RMS current meter.
`ifndef TWO_PASS_RMS_CURRENT_METER_ASSERT_SVH
`define TWO_PASS_RMS_CURRENT_METER_ASSERT_SVH
`ifndef SYNTHESIS
`define TRCM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TRCM_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TRCM_ASSERT(label, clk, rst_n, prop, msg)
`define TRCM_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

[rtl/trcm_pkg.sv]
// Shared types and constants of the two-pass RMS current meter.
package trcm_pkg;

  localparam int OUT_W       = 20;
  localparam int SC_W        = 13;
  localparam int GAIN_W      = 16;
  localparam int NF_W        = 20;
  localparam int KIND_W      = 2;
  localparam int SCALE_SHIFT = 16;
  localparam int PROD_SHIFT  = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = 2;

  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN         = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_NOISE_FLOOR  = 2'd2;

  localparam logic [SC_W-1:0]   SC_RESET   = 13'd1000;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6188;
  localparam logic [NF_W-1:0]   NF_RESET   = 20'd100;

  typedef enum logic [KIND_W-1:0] {
    K_BIAS      = 2'd0,
    K_BIAS_LAST = 2'd1,
    K_SQ        = 2'd2,
    K_SQ_LAST   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    BK_RUN,
    BK_BDIV,
    BK_SDIV,
    BK_SQRT,
    BK_MUL,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/trcm_front.sv]
// Front end: tracks pass and sample position, tags each sample for the back end.
module trcm_front #(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [trcm_pkg::SC_W-1:0] sample_count_i,
  input  logic                   fifo_full_i,
  output logic                   fifo_push_o,
  output logic [trcm_pkg::KIND_W+$clog2(MAX_SAMPLES+1)+SAMPLE_BITS-1:0] fifo_data_o
);
  import trcm_pkg::*;

  localparam int NW = $clog2(MAX_SAMPLES + 1);

  logic          phase_q, phase_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] n_eff;
  logic [NW-1:0] cnt_next;
  logic          last;
  kind_e         kind;

  always_comb begin
    if (sample_count_i == '0) begin
      n_eff = NW'(1);
    end else if (32'(sample_count_i) > 32'(MAX_SAMPLES)) begin
      n_eff = NW'(MAX_SAMPLES);
    end else begin
      n_eff = NW'(sample_count_i);
    end
  end

  assign cnt_next    = cnt_q + NW'(1);
  assign last        = (cnt_next >= n_eff);
  assign fifo_push_o = push_i && !fifo_full_i;

  always_comb begin
    if (phase_q) begin
      kind = last ? K_SQ_LAST : K_SQ;
    end else begin
      kind = last ? K_BIAS_LAST : K_BIAS;
    end
  end

  assign fifo_data_o = {kind, n_eff, sample_i};

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (fifo_push_o) begin
      if (last) begin
        cnt_d   = '0;
        phase_d = !phase_q;
      end else begin
        cnt_d = cnt_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/trcm_fifo.sv]
// Short register queue between front end and back end.
module trcm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             wr, rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (rd) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (wr && !rd) begin
      cnt_d = cnt_q + CW'(1);
    end else if (rd && !wr) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/trcm_div.sv]
// Restoring divider, one quotient bit per cycle.
module trcm_div #(
  parameter int DIVIDEND_W = 53,
  parameter int DIVISOR_W  = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output trcm_pkg::div_stat_t   stat_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);
  import trcm_pkg::*;

  localparam int CNTW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d, done_q, done_d;
  logic [CNTW-1:0]       cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d, dvs_q, dvs_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W:0]    rem_sh, rem_sub;
  logic                  ge;

  assign rem_sh  = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(DIVIDEND_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

[rtl/trcm_back.sv]
// Back end: bias and square accumulation, root, scaling and result register.
module trcm_back #(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fifo_empty_i,
  input  logic [trcm_pkg::KIND_W+$clog2(MAX_SAMPLES+1)+SAMPLE_BITS-1:0] fifo_data_i,
  output logic                         fifo_pop_o,
  output logic                         div_start_o,
  output logic [2*SAMPLE_BITS+$clog2(MAX_SAMPLES+1)+trcm_pkg::SCALE_SHIFT-1:0] div_dividend_o,
  output logic [$clog2(MAX_SAMPLES+1)-1:0] div_divisor_o,
  input  trcm_pkg::div_stat_t          div_stat_i,
  input  logic [2*SAMPLE_BITS+$clog2(MAX_SAMPLES+1)+trcm_pkg::SCALE_SHIFT-1:0] div_quo_i,
  input  logic [trcm_pkg::GAIN_W-1:0]  gain_i,
  input  logic [trcm_pkg::NF_W-1:0]    noise_floor_i,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [trcm_pkg::OUT_W-1:0]   current_ma_o,
  output logic [SAMPLE_BITS-1:0]       bias_level_o,
  output logic [trcm_pkg::OUT_W-1:0]   rms_counts_o
);
  import trcm_pkg::*;
  `include "two_pass_rms_current_meter_assert.svh"

  localparam int SB   = SAMPLE_BITS;
  localparam int NW   = $clog2(MAX_SAMPLES + 1);
  localparam int EW   = KIND_W + NW + SB;
  localparam int BSW  = SB + NW;
  localparam int SSW  = 2 * SB + NW;
  localparam int DW   = SSW + SCALE_SHIFT;
  localparam int RW   = (DW + 1) / 2;
  localparam int RCW  = $clog2(RW + 1);
  localparam int PW   = RW + GAIN_W;
  localparam int CMPW = (RW > OUT_W) ? RW : OUT_W;

  back_state_e state_q, state_d;

  kind_e         kind;
  logic [SB-1:0] smp;
  logic [NW-1:0] n_ent;

  logic [BSW-1:0]  bias_sum_q, bias_sum_d, b_acc;
  logic [SSW-1:0]  sq_sum_q, sq_sum_d, sq_acc;
  logic [SB-1:0]   bias_q, bias_d, dev;
  logic [2*SB-1:0] dev_sq;

  logic [2*RW-1:0] rad_q, rad_d;
  logic [RW+1:0]   rem_q, rem_d, rem_sh, trial, rem_sub;
  logic [RW-1:0]   root_q, root_d;
  logic [RCW-1:0]  sqrt_cnt_q, sqrt_cnt_d;
  logic [PW-1:0]   prod_q, prod_d;

  logic            out_valid_q, out_valid_d;
  logic [OUT_W-1:0] cur_q, cur_d, rms_q, rms_d;
  logic [SB-1:0]   bias_out_q, bias_out_d;
  logic [CMPW-1:0] cur_ext, nf_ext, root_ext;

  logic fifo_pop, div_start, sqrt_load, sqrt_step, mul_en, out_load, out_take;

  assign kind  = kind_e'(fifo_data_i[EW-1 -: KIND_W]);
  assign n_ent = fifo_data_i[SB +: NW];
  assign smp   = fifo_data_i[SB-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_RUN: begin
        if (!fifo_empty_i && kind == K_BIAS_LAST) begin
          state_d = BK_BDIV;
        end else if (!fifo_empty_i && kind == K_SQ_LAST) begin
          state_d = BK_SDIV;
        end
      end
      BK_BDIV: begin
        if (div_stat_i.done) state_d = BK_RUN;
      end
      BK_SDIV: begin
        if (div_stat_i.done) state_d = BK_SQRT;
      end
      BK_SQRT: begin
        if (sqrt_cnt_q == RCW'(1)) state_d = BK_MUL;
      end
      BK_MUL: state_d = BK_OUT;
      BK_OUT: begin
        if (!out_valid_q || pop_i) state_d = BK_RUN;
      end
      default: state_d = BK_RUN;
    endcase
  end

  // state outputs
  always_comb begin
    fifo_pop  = 1'b0;
    div_start = 1'b0;
    sqrt_load = 1'b0;
    sqrt_step = 1'b0;
    mul_en    = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      BK_RUN: begin
        fifo_pop  = !fifo_empty_i;
        div_start = !fifo_empty_i && (kind == K_BIAS_LAST || kind == K_SQ_LAST);
      end
      BK_BDIV: ;
      BK_SDIV: sqrt_load = div_stat_i.done;
      BK_SQRT: sqrt_step = 1'b1;
      BK_MUL:  mul_en = 1'b1;
      BK_OUT:  out_load = !out_valid_q || pop_i;
      default: ;
    endcase
  end

  assign dev    = (smp >= bias_q) ? (smp - bias_q) : (bias_q - smp);
  assign dev_sq = (2*SB)'(dev) * (2*SB)'(dev);
  assign b_acc  = bias_sum_q + BSW'(smp);
  assign sq_acc = sq_sum_q + SSW'(dev_sq);

  assign div_dividend_o = (kind == K_SQ_LAST) ? {sq_acc, {SCALE_SHIFT{1'b0}}} : DW'(b_acc);
  assign div_divisor_o  = n_ent;
  assign div_start_o    = div_start;
  assign fifo_pop_o     = fifo_pop;

  assign rem_sh  = {rem_q[RW-1:0], rad_q[2*RW-1 -: 2]};
  assign trial   = {root_q, 2'b01};
  assign rem_sub = rem_sh - trial;

  assign cur_ext  = CMPW'(prod_q[PROD_SHIFT +: RW]);
  assign nf_ext   = CMPW'(noise_floor_i);
  assign root_ext = CMPW'(root_q);
  assign out_take = pop_i && out_valid_q;

  always_comb begin
    bias_sum_d  = bias_sum_q;
    sq_sum_d    = sq_sum_q;
    bias_d      = bias_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    sqrt_cnt_d  = sqrt_cnt_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q;
    cur_d       = cur_q;
    rms_d       = rms_q;
    bias_out_d  = bias_out_q;

    if (fifo_pop) begin
      case (kind)
        K_BIAS:      bias_sum_d = b_acc;
        K_BIAS_LAST: bias_sum_d = '0;
        K_SQ:        sq_sum_d   = sq_acc;
        K_SQ_LAST:   sq_sum_d   = '0;
        default:     ;
      endcase
    end
    if (state_q == BK_BDIV && div_stat_i.done) begin
      bias_d = div_quo_i[SB-1:0];
    end
    if (sqrt_load) begin
      rad_d      = (2*RW)'(div_quo_i);
      rem_d      = '0;
      root_d     = '0;
      sqrt_cnt_d = RCW'(RW);
    end else if (sqrt_step) begin
      rad_d      = {rad_q[2*RW-3:0], 2'b00};
      sqrt_cnt_d = sqrt_cnt_q - RCW'(1);
      if (rem_sh >= trial) begin
        rem_d  = rem_sub;
        root_d = {root_q[RW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RW-2:0], 1'b0};
      end
    end
    if (mul_en) begin
      prod_d = PW'(root_q) * PW'(gain_i);
    end

    if (out_take) out_valid_d = 1'b0;
    if (out_load) begin
      out_valid_d = 1'b1;
      cur_d       = (cur_ext < nf_ext) ? '0 : cur_ext[OUT_W-1:0];
      rms_d       = root_ext[OUT_W-1:0];
      bias_out_d  = bias_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      bias_sum_q  <= '0;
      sq_sum_q    <= '0;
      bias_q      <= '0;
      sqrt_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bias_sum_q  <= bias_sum_d;
      sq_sum_q    <= sq_sum_d;
      bias_q      <= bias_d;
      sqrt_cnt_q  <= sqrt_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q      <= rad_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    prod_q     <= prod_d;
    cur_q      <= cur_d;
    rms_q      <= rms_d;
    bias_out_q <= bias_out_d;
  end

  assign empty_o      = !out_valid_q;
  assign current_ma_o = cur_q;
  assign rms_counts_o = rms_q;
  assign bias_level_o = bias_out_q;

  `TRCM_ASSERT(a_div_start_idle, clk_i, rst_ni, div_start |-> !div_stat_i.busy, "divider restarted while busy")
  `TRCM_ASSERT(a_div_done_state, clk_i, rst_ni, div_stat_i.done |-> (state_q == BK_BDIV || state_q == BK_SDIV), "divider finished outside a divide state")
  `TRCM_ASSERT(a_sqrt_cnt_live, clk_i, rst_ni, (state_q == BK_SQRT) |-> (sqrt_cnt_q != '0), "root step count ran out early")
  `TRCM_ASSERT(a_result_hold, clk_i, rst_ni, (out_valid_q && !pop_i) |=> (out_valid_q && $stable(cur_q) && $stable(rms_q)), "waiting result overwritten")

endmodule

[rtl/two_pass_rms_current_meter.sv]
// Two-pass RMS current meter: APB registers, front end, queue, divider, back end.
// Samples are taken one per cycle while the back end accumulates; the queue holds four more.
// After the bias pass the back end stops while the divider works on the 53-bit dividend.
// After the square pass it divides, takes 27 root steps, multiplies by the gain and loads
// the result register; that load waits while an earlier result is unread.
// Reset clears pass state, sums, queue and result; registers return to 1000, 6188, 100.
module two_pass_rms_current_meter #(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [trcm_pkg::OUT_W-1:0]        current_ma_o,
  output logic [SAMPLE_BITS-1:0]            bias_level_o,
  output logic [trcm_pkg::OUT_W-1:0]        rms_counts_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [trcm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [trcm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [trcm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import trcm_pkg::*;

  localparam int NW = $clog2(MAX_SAMPLES + 1);
  localparam int EW = KIND_W + NW + SAMPLE_BITS;
  localparam int DW = 2 * SAMPLE_BITS + NW + SCALE_SHIFT;

  logic [SC_W-1:0]   sc_q, sc_d;
  logic [GAIN_W-1:0] gain_q, gain_d;
  logic [NF_W-1:0]   nf_q, nf_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic              cfg_wr;

  logic          f_push, f_pop, f_full, f_empty;
  logic [EW-1:0] f_wdata, f_rdata;
  logic          div_start;
  logic [DW-1:0] div_dividend, div_quo;
  logic [NW-1:0] div_divisor;
  div_stat_t     div_stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    sc_d   = sc_q;
    gain_d = gain_q;
    nf_d   = nf_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_SAMPLE_COUNT: sc_d   = pwdata[SC_W-1:0];
        REG_GAIN:         gain_d = pwdata[GAIN_W-1:0];
        REG_NOISE_FLOOR:  nf_d   = pwdata[NF_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SAMPLE_COUNT: prdata = APB_DATA_W'(sc_q);
      REG_GAIN:         prdata = APB_DATA_W'(gain_q);
      REG_NOISE_FLOOR:  prdata = APB_DATA_W'(nf_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q   <= SC_RESET;
      gain_q <= GAIN_RESET;
      nf_q   <= NF_RESET;
    end else begin
      sc_q   <= sc_d;
      gain_q <= gain_d;
      nf_q   <= nf_d;
    end
  end

  assign full = f_full;

  trcm_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .sample_i       (sample_i),
    .sample_count_i (sc_q),
    .fifo_full_i    (f_full),
    .fifo_push_o    (f_push),
    .fifo_data_o    (f_wdata)
  );

  trcm_fifo #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_wdata),
    .pop_i   (f_pop),
    .rdata_o (f_rdata),
    .full_o  (f_full),
    .empty_o (f_empty)
  );

  trcm_div #(
    .DIVIDEND_W(DW),
    .DIVISOR_W (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  trcm_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_empty_i   (f_empty),
    .fifo_data_i    (f_rdata),
    .fifo_pop_o     (f_pop),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_stat_i     (div_stat),
    .div_quo_i      (div_quo),
    .gain_i         (gain_q),
    .noise_floor_i  (nf_q),
    .pop_i          (pop),
    .empty_o        (empty),
    .current_ma_o   (current_ma_o),
    .bias_level_o   (bias_level_o),
    .rms_counts_o   (rms_counts_o)
  );

endmodule

[tb/sv/tb_two_pass_rms_current_meter.sv]
// Testbench for the two-pass RMS current meter: sample stream, APB setup, reading checks.
`timescale 1ns / 100ps

module tb_two_pass_rms_current_meter;
  import trcm_pkg::*;

  localparam int SMP_W         = 12;
  localparam int MAX_N         = 4096;
  localparam int SETTLE_CYCLES = 300;
  localparam int LIMIT_CYCLES  = 1000000;

  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [OUT_W-1:0] current_ma;
    logic [SMP_W-1:0] bias_level;
    logic [OUT_W-1:0] rms_counts;
  } reading_t;

  typedef enum int {
    SHAPE_UNIFORM,
    SHAPE_NARROW,
    SHAPE_RAILS
  } sample_shape_e;

  class rms_reading_board;
    logic [SC_W-1:0]   cfg_samples = SC_RESET;
    logic [GAIN_W-1:0] cfg_gain    = GAIN_RESET;
    logic [NF_W-1:0]   cfg_floor   = NF_RESET;

    bit                in_rms_pass = 1'b0;
    int unsigned       pass_count  = 0;
    longint unsigned   dc_sum      = 0;
    logic [SMP_W-1:0]  dc_level    = '0;
    longint unsigned   dev_sq_sum  = 0;

    reading_t          pending_readings[$];
    int unsigned       failures         = 0;
    int unsigned       readings_checked = 0;

    function void write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
      case (idx)
        REG_SAMPLE_COUNT: cfg_samples = value[SC_W-1:0];
        REG_GAIN:         cfg_gain    = value[GAIN_W-1:0];
        REG_NOISE_FLOOR:  cfg_floor   = value[NF_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(input logic [REG_IDX_W-1:0] idx);
      case (idx)
        REG_SAMPLE_COUNT: return 32'(cfg_samples);
        REG_GAIN:         return 32'(cfg_gain);
        REG_NOISE_FLOOR:  return 32'(cfg_floor);
        default:          return 32'd0;
      endcase
    endfunction

    function int unsigned eff_count();
      int unsigned n;
      n = cfg_samples;
      if (n == 0) n = 1;
      if (n > MAX_N) n = MAX_N;
      return n;
    endfunction

    function longint unsigned root_floor(input longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 27; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function void take_sample(input logic [SMP_W-1:0] s);
      int unsigned     n;
      longint unsigned sv;
      longint unsigned lvl;
      longint unsigned dev;
      longint unsigned rms;
      longint unsigned amps;
      reading_t        r;
      n = eff_count();
      sv = s;
      pass_count++;
      if (!in_rms_pass) begin
        dc_sum += sv;
        if (pass_count >= n) begin
          dc_level    = SMP_W'(dc_sum / n);
          dc_sum      = 0;
          pass_count  = 0;
          in_rms_pass = 1'b1;
        end
        return;
      end
      lvl = dc_level;
      dev = (sv >= lvl) ? sv - lvl : lvl - sv;
      dev_sq_sum += dev * dev;
      if (pass_count < n) return;
      rms  = root_floor((dev_sq_sum << 16) / n);
      amps = (rms * cfg_gain) >> 16;
      if (amps < cfg_floor) amps = 0;
      r.current_ma = OUT_W'(amps);
      r.bias_level = dc_level;
      r.rms_counts = OUT_W'(rms);
      pending_readings.push_back(r);
      dev_sq_sum  = 0;
      pass_count  = 0;
      in_rms_pass = 1'b0;
    endfunction

    function int waiting();
      return pending_readings.size();
    endfunction

    function void check_reading(input reading_t got);
      reading_t want;
      readings_checked++;
      if (pending_readings.size() == 0) begin
        $error("unexpected reading: current_ma %0d bias_level %0d rms_counts %0d",
               got.current_ma, got.bias_level, got.rms_counts);
        failures++;
        return;
      end
      want = pending_readings.pop_front();
      if (got.current_ma !== want.current_ma) begin
        $error("current_ma: expected %0d, got %0d", want.current_ma, got.current_ma);
        failures++;
      end
      if (got.bias_level !== want.bias_level) begin
        $error("bias_level: expected %0d, got %0d", want.bias_level, got.bias_level);
        failures++;
      end
      if (got.rms_counts !== want.rms_counts) begin
        $error("rms_counts: expected %0d, got %0d", want.rms_counts, got.rms_counts);
        failures++;
      end
    endfunction
  endclass

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  push     = 1'b0;
  logic                  full;
  logic [SMP_W-1:0]      sample_i = '0;
  logic                  empty;
  logic                  pop      = 1'b0;
  logic [OUT_W-1:0]      current_ma_o;
  logic [SMP_W-1:0]      bias_level_o;
  logic [OUT_W-1:0]      rms_counts_o;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rms_reading_board readings = new;

  bit tx_idle_on        = 1'b1;
  bit rx_idle_on        = 1'b1;
  int rx_holdoff_cycles = 0;
  int cycle_count       = 0;

  two_pass_rms_current_meter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .sample_i     (sample_i),
    .empty        (empty),
    .pop          (pop),
    .current_ma_o (current_ma_o),
    .bias_level_o (bias_level_o),
    .rms_counts_o (rms_counts_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("two_pass_rms_current_meter test failed");
      $finish;
    end
  end

  task automatic apb_xfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  task automatic check_reg(input logic [REG_IDX_W-1:0] idx);
    logic [31:0] got;
    apb_xfer(1'b0, idx, 32'd0, got);
    if (got !== readings.reg_value(idx)) begin
      $error("register %0d readback: expected 0x%0h, got 0x%0h",
             idx, readings.reg_value(idx), got);
      readings.failures++;
    end
  endtask

  task automatic program_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] unused;
    apb_xfer(1'b1, idx, value, unused);
    readings.write_reg(idx, value);
    if (idx != REG_SPARE) check_reg(idx);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_sample(input logic [SMP_W-1:0] value);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push     <= 1'b1;
    sample_i <= value;
    do @(posedge clk_i); while (full);
    readings.take_sample(value);
  endtask

  task automatic send_pair(input logic [SMP_W-1:0] a, input logic [SMP_W-1:0] b);
    send_sample(a);
    send_sample(b);
  endtask

  function automatic logic [SMP_W-1:0] draw_sample(input sample_shape_e shape,
                                                   input int center, input int spread);
    int v;
    case (shape)
      SHAPE_NARROW: begin
        v = center + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      SHAPE_RAILS: v = $urandom_range(0, 1) ? 4095 : 0;
      default:     v = $urandom_range(0, 4095);
    endcase
    return SMP_W'(v);
  endfunction

  task automatic send_samples(input int count, input sample_shape_e shape,
                              input int center, input int spread);
    repeat (count) send_sample(draw_sample(shape, center, spread));
  endtask

  // drop the request, wait for every reading, then let the back end go quiet
  task automatic settle();
    push <= 1'b0;
    while (readings.waiting() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    reading_t got;
    int       gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 15) : 0;
      if (rx_holdoff_cycles > 0) begin
        gap = rx_holdoff_cycles;
        rx_holdoff_cycles = 0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got.current_ma = current_ma_o;
      got.bias_level = bias_level_o;
      got.rms_counts = rms_counts_o;
      readings.check_reading(got);
    end
  end

  initial begin
    int            random_items;
    int            n_eff;
    int            count;
    int            pick;
    int            nval;
    sample_shape_e shape;
    random_items = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 3; i++) check_reg(REG_IDX_W'(i));
    psel    <= 1'b0;
    penable <= 1'b0;

    // one-sample passes at full gain, rails in every order
    program_reg(REG_SAMPLE_COUNT, 32'd1);
    program_reg(REG_GAIN, 32'hFFFF_FFFF);
    program_reg(REG_NOISE_FLOOR, 32'd0);
    send_pair(12'd0, 12'd4095);
    send_pair(12'd4095, 12'd0);
    send_pair(12'd4095, 12'd4095);
    send_pair(12'd0, 12'd0);

    // current right at the floor, then one above it
    settle();
    program_reg(REG_NOISE_FLOOR, 32'd1048304);
    send_pair(12'd0, 12'd4095);
    settle();
    program_reg(REG_NOISE_FLOOR, 32'd1048305);
    send_pair(12'd0, 12'd4095);

    settle();
    program_reg(REG_GAIN, 32'd0);
    program_reg(REG_NOISE_FLOOR, 32'd0);
    send_pair(12'd123, 12'd4000);

    // zero count acts as one, floor at max, write past the register map
    settle();
    program_reg(REG_SAMPLE_COUNT, 32'd0);
    program_reg(REG_GAIN, 32'd6188);
    program_reg(REG_NOISE_FLOOR, 32'h000F_FFFF);
    program_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_pair(12'd2048, 12'd1);

    // count lowered in the middle of the square pass
    settle();
    program_reg(REG_SAMPLE_COUNT, 32'd4);
    program_reg(REG_NOISE_FLOOR, 32'd0);
    repeat (4) send_sample(12'd4000);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd17);
    settle();
    program_reg(REG_SAMPLE_COUNT, 32'd2);
    send_sample(12'd2222);

    // count lowered in the middle of the bias pass, bias wraps
    settle();
    program_reg(REG_SAMPLE_COUNT, 32'd8);
    repeat (5) send_sample(12'd4095);
    settle();
    program_reg(REG_SAMPLE_COUNT, 32'd2);
    send_sample(12'd4095);
    send_pair(12'd0, 12'd4095);

    // readings back up while the receiver holds off
    settle();
    program_reg(REG_SAMPLE_COUNT, 32'd1);
    tx_idle_on        = 1'b0;
    rx_holdoff_cycles = 400;
    send_samples(40, SHAPE_UNIFORM, 0, 0);

    while (random_items < 630) begin
      settle();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 19);
        if (pick < 14)      nval = $urandom_range(1, 8);
        else if (pick < 19) nval = $urandom_range(9, 40);
        else                nval = 0;
        program_reg(REG_SAMPLE_COUNT, ($urandom() & 32'hFFFF_E000) | 32'(nval));
        program_reg(REG_GAIN, $urandom());
        program_reg(REG_NOISE_FLOOR,
                    $urandom_range(0, 1) ? 32'($urandom_range(0, 2000)) : $urandom());
      end
      n_eff = readings.eff_count();
      count = 2 * n_eff * ((n_eff <= 8) ? $urandom_range(2, 6) : $urandom_range(1, 2));
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, 2 * n_eff - 1);
      shape = sample_shape_e'($urandom_range(0, 2));
      send_samples(count, shape, $urandom_range(0, 4095), $urandom_range(0, 300));
      random_items += count;
    end

    settle();
    if (readings.failures == 0) begin
      $display("two_pass_rms_current_meter test passed");
    end else begin
      $display("two_pass_rms_current_meter test failed");
    end
    $finish;
  end

endmodule
